FILE: rtl/core/max_profit_k_trades_assert.svh
`ifndef MAX_PROFIT_K_TRADES_ASSERT_SVH
`define MAX_PROFIT_K_TRADES_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MPKT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MPKT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mpkt_pkg.sv
package mpkt_pkg;

  localparam int OUT_W  = 20;
  localparam int CFG_W  = 5;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int IN_W   = 16;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // register indexes
  localparam int REG_MAX_TRANS = 0;

  localparam logic [CFG_W-1:0] MAX_TRANS_RST = 5'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } mpkt_state_e;

  // what the slice decided for one count of completed sales
  typedef struct packed {
    logic hold_wr;
    logic cash_wr;
    logic cash_ok;
  } mpkt_slice_ctl_t;

endpackage

FILE: rtl/core/mpkt_slice.sv
module mpkt_slice #(
  parameter int VAL_W = 22
) (
  input  logic signed [VAL_W-1:0] price_i,
  input  logic signed [VAL_W-1:0] cprev_i,
  input  logic                    cprev_ok_i,
  input  logic signed [VAL_W-1:0] hold_i,
  input  logic                    hold_ok_i,
  input  logic signed [VAL_W-1:0] cash_i,
  input  logic                    cash_ok_i,
  input  logic signed [VAL_W-1:0] best_i,
  output logic signed [VAL_W-1:0] buy_o,
  output logic signed [VAL_W-1:0] sell_o,
  output logic signed [VAL_W-1:0] best_o,
  output mpkt_pkg::mpkt_slice_ctl_t ctl_o
);
  import mpkt_pkg::*;

  logic signed [VAL_W-1:0] cash_new;

  always_comb begin
    buy_o  = cprev_i - price_i;
    sell_o = hold_i + price_i;

    ctl_o.hold_wr = cprev_ok_i && (!hold_ok_i || (buy_o > hold_i));
    ctl_o.cash_wr = hold_ok_i && (!cash_ok_i || (sell_o > cash_i));
    ctl_o.cash_ok = cash_ok_i || hold_ok_i;

    // fold the freshly settled cash entry into the running best
    cash_new = ctl_o.cash_wr ? sell_o : cash_i;
    best_o   = (ctl_o.cash_ok && (cash_new > best_i)) ? cash_new : best_i;
  end

endmodule

FILE: rtl/core/max_profit_k_trades.sv
// sequence: accept step, then one slice step per trade count up to the limit K and
//   a closing step, which registers the profit when the price was the last one
// a new price is taken only in idle, after the single shared slice has walked
//   the trade counts in turn; K is the limit in force when the price is taken;
//   a last price waits in the closing cycle while an earlier profit beat is stalled
// reset: tables empty (no cash but the zero entry, no holding), limit 2, no result
module max_profit_k_trades #(
  parameter int MAX_TRADES = 16,
  parameter int PRICE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mpkt_pkg::ADDR_W-1:0]    paddr,
  input  logic [mpkt_pkg::DATA_W-1:0]    pwdata,
  output logic [mpkt_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mpkt_pkg::IN_W-1:0]      price_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mpkt_pkg::OUT_W-1:0]     max_profit_o
);
  import mpkt_pkg::*;

  `include "max_profit_k_trades_assert.svh"

  localparam int CNT_W = $clog2(MAX_TRADES + 1);
  localparam int IDX_W = (MAX_TRADES > 1) ? $clog2(MAX_TRADES) : 1;
  localparam int VAL_W = PRICE_BITS + CNT_W + 1;
  localparam int EXT_W = VAL_W + OUT_W;
  localparam logic [31:0] PMASK = 32'((64'(1) << PRICE_BITS) - 64'(1));

  // configuration
  logic [CFG_W-1:0] max_trans_q;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1:2] == 1'(REG_MAX_TRANS));
  assign prdata  = reg_sel ? DATA_W'(max_trans_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_trans_q <= MAX_TRANS_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_trans_q <= pwdata[CFG_W-1:0];
    end
  end

  // sequencer
  mpkt_state_e state_q, state_d;
  logic [CNT_W-1:0] t_q, k_q;
  logic             last_q;
  logic             accept, step_en, fin_load;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d  = state_q;
    step_en  = 1'b0;
    fin_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (t_q != k_q) begin
          step_en = 1'b1;
        end else if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          fin_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      t_q     <= '0;
      k_q     <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        t_q    <= '0;
        k_q    <= (int'(max_trans_q) > MAX_TRADES) ? CNT_W'(MAX_TRADES) : CNT_W'(max_trans_q);
        last_q <= last_i;
      end else if (step_en) begin
        t_q <= t_q + CNT_W'(1);
      end
    end
  end

  // tables: cash entry t+1 sits at cash_q[t], entry zero is always 0
  logic signed [VAL_W-1:0] cash_q [MAX_TRADES];
  logic signed [VAL_W-1:0] hold_q [MAX_TRADES];
  logic [MAX_TRADES-1:0]   cash_v_q, hold_v_q;
  logic signed [VAL_W-1:0] price_q, cprev_q, best_q;
  logic                    cprev_v_q;
  logic [31:0]             price_m;
  logic [IDX_W-1:0]        idx;

  logic signed [VAL_W-1:0] buy, sell, best_nxt;
  mpkt_slice_ctl_t         ctl;

  assign price_m = {16'b0, price_i} & PMASK;
  assign idx     = t_q[IDX_W-1:0];

  mpkt_slice #(
    .VAL_W(VAL_W)
  ) u_slice (
    .price_i   (price_q),
    .cprev_i   (cprev_q),
    .cprev_ok_i(cprev_v_q),
    .hold_i    (hold_q[idx]),
    .hold_ok_i (hold_v_q[idx]),
    .cash_i    (cash_q[idx]),
    .cash_ok_i (cash_v_q[idx]),
    .best_i    (best_q),
    .buy_o     (buy),
    .sell_o    (sell),
    .best_o    (best_nxt),
    .ctl_o     (ctl)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      price_q <= signed'(VAL_W'(price_m));
      cprev_q <= '0;
      best_q  <= '0;
    end else if (step_en) begin
      // old cash of the next count, read before this step overwrites it
      cprev_q <= cash_q[idx];
      best_q  <= best_nxt;
      if (ctl.hold_wr) begin
        hold_q[idx] <= buy;
      end
      if (ctl.cash_wr) begin
        cash_q[idx] <= sell;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cash_v_q  <= '0;
      hold_v_q  <= '0;
      cprev_v_q <= 1'b0;
    end else if (fin_load) begin
      cash_v_q <= '0;
      hold_v_q <= '0;
    end else if (accept) begin
      cprev_v_q <= 1'b1;
    end else if (step_en) begin
      cprev_v_q <= cash_v_q[idx];
      if (ctl.hold_wr) begin
        hold_v_q[idx] <= 1'b1;
      end
      if (ctl.cash_wr) begin
        cash_v_q[idx] <= 1'b1;
      end
    end
  end

  // result register with saturation to the output field
  logic [EXT_W-1:0] best_ext;
  logic [OUT_W-1:0] result;

  assign best_ext = {{OUT_W{1'b0}}, best_q};
  assign result   = (best_ext > EXT_W'(OUT_MAX)) ? OUT_MAX : best_ext[OUT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign max_profit_o = out_data_q;

  `MPKT_ASSERT_IMP(a_step_in_range, state_q == ST_RUN, t_q <= k_q, "step count past limit")
  `MPKT_ASSERT_IMP(a_load_on_last, fin_load, last_q && (t_q == k_q), "result without last beat")
  `MPKT_ASSERT_NXT(a_clear_after_load, fin_load,
                   (cash_v_q == '0) && (hold_v_q == '0) && out_valid_q,
                   "tables not cleared after result")

endmodule
